// ===== design/sfc_pkg.sv =====
`default_nettype none
package sfc_pkg;

  localparam int unsigned DATA_W       = 64;
  localparam int unsigned VB_W         = 4;
  localparam int unsigned IDX_W        = 4;
  localparam int unsigned CNT_W        = 5;
  localparam int unsigned STRIPE_LIMIT = 16;
  localparam int unsigned WIDE_BYTES   = 8;
  localparam int unsigned NARROW_BYTES = 4;
  localparam int unsigned NARROW_BITS  = 32;
  localparam int unsigned APB_AW       = 3;
  localparam int unsigned APB_DW       = 32;

  localparam logic [DATA_W-1:0] NARROW_MASK =
    {{(DATA_W-NARROW_BITS){1'b0}}, {NARROW_BITS{1'b1}}};

  localparam logic REG_WIDE_WORDS   = 1'b0;
  localparam logic REG_STRIPE_COUNT = 1'b1;

  // Keeps the bytes below the valid count, limited to the word width of the mode.
  function automatic logic [DATA_W-1:0] byte_mask(input logic [VB_W-1:0] nb,
                                                  input logic wide);
    logic [DATA_W-1:0] m;
    m = '0;
    for (int b = 0; b < WIDE_BYTES; b++) begin
      m[8*b +: 8] = {8{(VB_W'(b) < nb) && (wide || (b < NARROW_BYTES))}};
    end
    return m;
  endfunction

endpackage
`default_nettype wire

// ===== design/sfc_in_if.sv =====
`default_nettype none
interface sfc_in_if
  import sfc_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] data_word;
  logic [VB_W-1:0]   valid_bytes;
  logic              last_word;

  modport source (output valid, output data_word, output valid_bytes, output last_word,
                  input ready);
  modport sink (input valid, input data_word, input valid_bytes, input last_word,
                output ready);
endinterface
`default_nettype wire

// ===== design/sfc_out_if.sv =====
`default_nettype none
interface sfc_out_if
  import sfc_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [IDX_W-1:0]  stripe_index;
  logic [DATA_W-1:0] sum_high;
  logic [DATA_W-1:0] sum_low;
  logic              final_stripe;

  modport source (output valid, output stripe_index, output sum_high, output sum_low,
                  output final_stripe, input ready);
  modport sink (input valid, input stripe_index, input sum_high, input sum_low,
                input final_stripe, output ready);
endinterface
`default_nettype wire

// ===== design/striped_fletcher_checksum_top.sv =====
// Striped checksum engine with low and high running sums per stripe, kept in two
// single-port-write, registered-read stripe memories. An input word with valid bytes
// goes through acceptance with the memory read, the low-sum add and the high-sum add with
// write-back; one with no valid bytes ends at acceptance. On the last word every active
// stripe is read back and presented, each by a read state and a load state that waits
// for a free output, and then input is accepted again. Each stripe entry has a valid
// flag that reset and the end of a message clear at once, so no clearing pass is needed.
`default_nettype none
module striped_fletcher_checksum_top
  import sfc_pkg::*;
#(
  parameter int unsigned MAX_STRIPES = 16
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  sfc_in_if.sink                 in_i,
  sfc_out_if.source              out_o,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [APB_AW-1:0] paddr,
  input  wire logic [APB_DW-1:0] pwdata,
  output logic      [APB_DW-1:0] prdata,
  output logic                   pready
);

  localparam int unsigned IW   = (MAX_STRIPES > 1) ? $clog2(MAX_STRIPES) : 1;
  localparam int unsigned LIM  = (MAX_STRIPES < STRIPE_LIMIT) ? MAX_STRIPES : STRIPE_LIMIT;
  localparam int unsigned CMPW = (IW > CNT_W) ? IW : CNT_W;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SUM_LOW,
    ST_SUM_HIGH,
    ST_EMIT_RD,
    ST_EMIT_LOAD
  } state_e;

  state_e             state_q;
  logic               wide_q;
  logic [CNT_W-1:0]   stripes_q;
  logic [IW-1:0]      ptr_q;
  logic [IW-1:0]      sel_q;
  logic [IW-1:0]      emit_q;
  logic [CNT_W-1:0]   cnt_q;
  logic               item_wide_q;
  logic               last_q;
  logic [DATA_W-1:0]  word_q;
  logic [DATA_W-1:0]  low_q;
  logic [MAX_STRIPES-1:0] vld_q;
  logic               out_valid_q;
  logic [IDX_W-1:0]   out_idx_q;
  logic [DATA_W-1:0]  out_high_q;
  logic [DATA_W-1:0]  out_low_q;
  logic               out_final_q;

  logic [DATA_W-1:0] low_mem  [MAX_STRIPES];
  logic [DATA_W-1:0] high_mem [MAX_STRIPES];
  logic [DATA_W-1:0] low_rd_q;
  logic [DATA_W-1:0] high_rd_q;

  logic              accept;
  logic [CNT_W-1:0]  act_cnt;
  logic [IW-1:0]     sel_d;
  logic              mem_re;
  logic [IW-1:0]     mem_raddr;
  logic              mem_we;
  logic [DATA_W-1:0] low_d;
  logic [DATA_W-1:0] high_d;
  logic [DATA_W-1:0] rd_low;
  logic [DATA_W-1:0] rd_high;
  logic [DATA_W-1:0] res_mask;
  logic [CMPW-1:0]   sel_inc;
  logic              emit_final;
  logic              out_free;
  logic              emit_load;
  logic              cfg_we;

  assign accept   = in_i.valid && in_i.ready;
  assign in_i.ready = (state_q == ST_IDLE);
  assign cfg_we   = psel && penable && pwrite;
  assign pready   = 1'b1;
  assign out_free = !out_valid_q || out_o.ready;
  assign emit_load = (state_q == ST_EMIT_LOAD) && out_free;

  always_comb begin
    if (stripes_q == '0) begin
      act_cnt = CNT_W'(1);
    end else if (stripes_q > CNT_W'(LIM)) begin
      act_cnt = CNT_W'(LIM);
    end else begin
      act_cnt = stripes_q;
    end
    if (!wide_q) begin
      act_cnt = CNT_W'(1);
    end
  end

  always_comb begin
    if (!wide_q || (CMPW'(ptr_q) >= CMPW'(act_cnt))) begin
      sel_d = '0;
    end else begin
      sel_d = ptr_q;
    end
  end

  assign rd_low     = vld_q[sel_q] ? low_rd_q : '0;
  assign rd_high    = vld_q[sel_q] ? high_rd_q : '0;
  assign res_mask   = item_wide_q ? '1 : NARROW_MASK;
  assign low_d      = (rd_low + word_q) & res_mask;
  assign high_d     = (rd_high + low_q) & res_mask;
  assign sel_inc    = CMPW'(sel_q) + CMPW'(1);
  assign emit_final = (CMPW'(emit_q) == (CMPW'(cnt_q) - CMPW'(1)));

  assign mem_re    = accept || (state_q == ST_EMIT_RD);
  assign mem_raddr = (state_q == ST_EMIT_RD) ? emit_q : sel_d;
  assign mem_we    = (state_q == ST_SUM_HIGH);

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      low_mem[sel_q]  <= low_q;
      high_mem[sel_q] <= high_d;
    end
    if (mem_re) begin
      low_rd_q  <= low_mem[mem_raddr];
      high_rd_q <= high_mem[mem_raddr];
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_WIDE_WORDS:   prdata = APB_DW'(wide_q);
      REG_STRIPE_COUNT: prdata = APB_DW'(stripes_q);
      default:          prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      wide_q      <= 1'b1;
      stripes_q   <= CNT_W'(1);
      ptr_q       <= '0;
      sel_q       <= '0;
      emit_q      <= '0;
      cnt_q       <= CNT_W'(1);
      item_wide_q <= 1'b1;
      last_q      <= 1'b0;
      word_q      <= '0;
      low_q       <= '0;
      vld_q       <= '0;
      out_valid_q <= 1'b0;
      out_idx_q   <= '0;
      out_high_q  <= '0;
      out_low_q   <= '0;
      out_final_q <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (paddr[2])
          REG_WIDE_WORDS:   wide_q    <= pwdata[0];
          REG_STRIPE_COUNT: stripes_q <= pwdata[CNT_W-1:0];
          default:          wide_q    <= wide_q;
        endcase
      end
      if (out_valid_q && out_o.ready && !emit_load) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (accept) begin
            word_q      <= in_i.data_word & byte_mask(in_i.valid_bytes, wide_q);
            last_q      <= in_i.last_word;
            item_wide_q <= wide_q;
            cnt_q       <= act_cnt;
            sel_q       <= sel_d;
            emit_q      <= '0;
            if (in_i.valid_bytes != '0) begin
              state_q <= ST_SUM_LOW;
            end else if (in_i.last_word) begin
              state_q <= ST_EMIT_RD;
            end
          end
        end
        ST_SUM_LOW: begin
          low_q   <= low_d;
          state_q <= ST_SUM_HIGH;
        end
        ST_SUM_HIGH: begin
          vld_q[sel_q] <= 1'b1;
          if (item_wide_q) begin
            ptr_q <= (sel_inc >= CMPW'(cnt_q)) ? '0 : IW'(sel_inc);
          end
          state_q <= last_q ? ST_EMIT_RD : ST_IDLE;
        end
        ST_EMIT_RD: begin
          state_q <= ST_EMIT_LOAD;
        end
        ST_EMIT_LOAD: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            out_idx_q   <= IDX_W'(emit_q);
            out_high_q  <= (vld_q[emit_q] ? high_rd_q : '0) & res_mask;
            out_low_q   <= (vld_q[emit_q] ? low_rd_q : '0) & res_mask;
            out_final_q <= emit_final;
            if (emit_final) begin
              vld_q   <= '0;
              ptr_q   <= '0;
              state_q <= ST_IDLE;
            end else begin
              emit_q  <= emit_q + IW'(1);
              state_q <= ST_EMIT_RD;
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.stripe_index = out_idx_q;
  assign out_o.sum_high     = out_high_q;
  assign out_o.sum_low      = out_low_q;
  assign out_o.final_stripe = out_final_q;

endmodule
`default_nettype wire

// ===== design/sfc_checker.sv =====
`default_nettype none
module sfc_checker
  import sfc_pkg::*;
(
  input wire logic              clk_i,
  input wire logic              rst_ni,
  input wire logic              out_valid_i,
  input wire logic              out_ready_i,
  input wire logic [IDX_W-1:0]  out_stripe_index_i,
  input wire logic [DATA_W-1:0] out_sum_low_i,
  input wire logic              out_final_stripe_i
);

  logic [IDX_W-1:0] exp_idx_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_idx_q <= '0;
    end else if (out_valid_i && out_ready_i) begin
      exp_idx_q <= out_final_stripe_i ? '0 : out_stripe_index_i + IDX_W'(1);
    end
  end

  // Results of one message come in stripe order, starting from stripe zero.
  a_stripe_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (out_stripe_index_i == exp_idx_q))
    else $error("result stripe index out of order");

  // The highest stripe is always the last of its message.
  a_top_stripe_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && (out_stripe_index_i == '1)) |-> out_final_stripe_i)
    else $error("highest stripe not marked final");

  a_valid_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=> out_valid_i)
    else $error("result withdrawn before its transaction");

  a_payload_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=>
      ($stable(out_sum_low_i) && $stable(out_stripe_index_i)))
    else $error("stalled result changed");

endmodule

bind striped_fletcher_checksum_top sfc_checker u_sfc_checker (
  .clk_i              (clk_i),
  .rst_ni             (rst_ni),
  .out_valid_i        (out_o.valid),
  .out_ready_i        (out_o.ready),
  .out_stripe_index_i (out_o.stripe_index),
  .out_sum_low_i      (out_o.sum_low),
  .out_final_stripe_i (out_o.final_stripe)
);
`default_nettype wire
